// ===== sv/nta_pkg.sv =====
package nta_pkg;

   // Field widths of addresses, ages and event codes.
   localparam int ADDR_W = 48;
   localparam int AGE_W  = 8;
   localparam int KIND_W = 2;

   // Request codes carried on req_type.
   localparam logic REQ_BEACON = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   // Value of max_age after reset.
   localparam logic [AGE_W-1:0] MAX_AGE_RESET = 8'd3;

   // Event codes reported on the response channel.
   typedef enum logic [KIND_W-1:0] {
      KIND_NONE  = 2'd0,
      KIND_FOUND = 2'd1,
      KIND_LOST  = 2'd2,
      KIND_FULL  = 2'd3
   } kind_type;

   // One row of the neighbor table.
   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [AGE_W-1:0]  age;
      logic              is_new;
      logic              arrived;
   } entry_type;

   // Flags produced by the shared compare unit for the row under test.
   typedef struct packed {
      logic             hit;
      logic             expired;
      logic [AGE_W-1:0] age_inc;
   } eval_type;

   // One response word.
   typedef struct packed {
      kind_type          kind;
      logic [ADDR_W-1:0] address;
      logic              last;
   } rsp_type;

endpackage

// ===== sv/neighbor_table_aging.sv =====
// Neighbor table with aging timeout.
// Request channel (req_valid/req_ready): req_type selects a beacon from
// req_address or a periodic tick. Response channel (rsp_valid/rsp_ready):
// one or more words per request, rsp_last high on the final word.
// csr_wr_en/csr_wr_data write max_age; write it only while the block is idle.
// A beacon walks the stored entries one per cycle through a shared compare
// unit and answers with a single word.
// A tick makes two passes over the table, one entry per cycle each while the
// output is not stalled: the first ages entries and reports found neighbors,
// the second compacts the table and reports lost ones. The table holds at
// most TABLE_DEPTH entries.
// The table memory has one read and one write port, which sets the pace of
// one entry per cycle. One request is in work at a time; req_ready is low
// until its last word has entered the output register.
// Reset empties the table and sets max_age to 3; no clearing pass is needed.
// When the receiver stalls, the output register holds its word and the
// sweep pauses on the next event until the register frees up.
module neighbor_table_aging #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_type,
   input  logic [nta_pkg::ADDR_W-1:0]  req_address,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [nta_pkg::KIND_W-1:0]  rsp_event_kind,
   output logic [nta_pkg::ADDR_W-1:0]  rsp_event_address,
   output logic                        rsp_last,
   input  logic                        csr_wr_en,
   input  logic [nta_pkg::AGE_W-1:0]   csr_wr_data
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_BSCAN = 5'b00010,
      ST_TMARK = 5'b00100,
      ST_TPACK = 5'b01000,
      ST_FLUSH = 5'b10000
   } state_type;

   state_type                    state_ff, state_in;
   logic [CNT_W-1:0]             idx_ff, idx_in;
   logic [CNT_W-1:0]             wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [nta_pkg::AGE_W-1:0]    max_age_ff, max_age_in;
   logic [nta_pkg::ADDR_W-1:0]   key_ff, key_in;
   logic                         pend_valid_ff, pend_valid_in;
   nta_pkg::rsp_type             pend_ff, pend_in;

   logic                         mem_rd_en;
   logic [IDX_W-1:0]             mem_rd_addr;
   nta_pkg::entry_type           mem_rd_data;
   logic                         mem_wr_en;
   logic [IDX_W-1:0]             mem_wr_addr;
   nta_pkg::entry_type           mem_wr_data;

   logic                         out_valid;
   logic                         out_ready;
   nta_pkg::rsp_type             out_data;

   nta_pkg::eval_type            eval;
   logic [CNT_W-1:0]             idx_next;
   logic                         scan_end;
   logic                         more;
   logic                         step_ok;

   // Table storage.
   nta_mem #(
      .DEPTH (TABLE_DEPTH),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Shared compare unit, fed with the entry just read.
   nta_eval u_eval (
      .entry       (mem_rd_data),
      .key_address (key_ff),
      .max_age     (max_age_ff),
      .result      (eval)
   );

   // Output register that decouples the sweep from the receiver.
   nta_out u_out (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (out_valid),
      .in_ready          (out_ready),
      .in_data           (out_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_event_address (rsp_event_address),
      .rsp_last          (rsp_last)
   );

   assign idx_next = idx_ff + CNT_W'(1);
   assign scan_end = (idx_ff == count_ff);
   assign more     = (idx_next < count_ff);

   // Sequencer. One event word is kept pending so that the final one can be
   // marked last once the sweep is known to be over.
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      wr_ptr_in     = wr_ptr_ff;
      count_in      = count_ff;
      max_age_in    = csr_wr_en ? csr_wr_data : max_age_ff;
      key_in        = key_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      req_ready     = 1'b0;
      step_ok       = 1'b1;

      mem_rd_en     = 1'b0;
      mem_rd_addr   = '0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = idx_ff[IDX_W-1:0];
      mem_wr_data   = mem_rd_data;

      out_valid     = 1'b0;
      out_data      = pend_ff;
      out_data.last = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               key_in        = req_address;
               idx_in        = '0;
               wr_ptr_in     = '0;
               pend_valid_in = 1'b0;
               mem_rd_en     = (count_ff != '0);
               state_in      = (req_type == nta_pkg::REQ_TICK) ? ST_TMARK : ST_BSCAN;
            end
         end

         ST_BSCAN: begin
            if (scan_end) begin
               // Address absent: append it or report a full table.
               pend_valid_in   = 1'b1;
               pend_in.address = '0;
               pend_in.last    = 1'b0;
               if (count_ff == FULL_COUNT) begin
                  pend_in.kind = nta_pkg::KIND_FULL;
               end else begin
                  pend_in.kind        = nta_pkg::KIND_NONE;
                  mem_wr_en           = 1'b1;
                  mem_wr_addr         = count_ff[IDX_W-1:0];
                  mem_wr_data.address = key_ff;
                  mem_wr_data.age     = '0;
                  mem_wr_data.is_new  = 1'b1;
                  mem_wr_data.arrived = 1'b1;
                  count_in            = count_ff + CNT_W'(1);
               end
               state_in = ST_FLUSH;
            end else if (eval.hit) begin
               // Known address: mark arrived, restart the age of an old entry.
               mem_wr_en           = 1'b1;
               mem_wr_data.arrived = 1'b1;
               if (!mem_rd_data.is_new) begin
                  mem_wr_data.age = '0;
               end
               pend_valid_in   = 1'b1;
               pend_in.kind    = nta_pkg::KIND_NONE;
               pend_in.address = '0;
               pend_in.last    = 1'b0;
               state_in        = ST_FLUSH;
            end else begin
               idx_in      = idx_next;
               mem_rd_en   = more;
               mem_rd_addr = idx_next[IDX_W-1:0];
            end
         end

         ST_TMARK: begin
            if (scan_end) begin
               // Start the compaction pass from the first entry.
               idx_in    = '0;
               wr_ptr_in = '0;
               mem_rd_en = (count_ff != '0);
               state_in  = ST_TPACK;
            end else begin
               // Update in place; an entry to be removed is tagged with arrived set.
               mem_wr_data.is_new = 1'b0;
               if (mem_rd_data.arrived || mem_rd_data.is_new) begin
                  mem_wr_data.age     = '0;
                  mem_wr_data.arrived = 1'b0;
               end else if (eval.expired) begin
                  mem_wr_data.arrived = 1'b1;
               end else begin
                  mem_wr_data.age = eval.age_inc;
               end
               if (mem_rd_data.arrived && mem_rd_data.is_new) begin
                  out_valid = pend_valid_ff;
                  step_ok   = !pend_valid_ff || out_ready;
                  if (step_ok) begin
                     pend_valid_in   = 1'b1;
                     pend_in.kind    = nta_pkg::KIND_FOUND;
                     pend_in.address = mem_rd_data.address;
                     pend_in.last    = 1'b0;
                  end
               end
               if (step_ok) begin
                  mem_wr_en   = 1'b1;
                  idx_in      = idx_next;
                  mem_rd_en   = more;
                  mem_rd_addr = idx_next[IDX_W-1:0];
               end
            end
         end

         ST_TPACK: begin
            if (scan_end) begin
               count_in = wr_ptr_ff;
               state_in = ST_FLUSH;
            end else begin
               if (mem_rd_data.arrived) begin
                  // Tagged entry: report it lost and leave it out.
                  out_valid = pend_valid_ff;
                  step_ok   = !pend_valid_ff || out_ready;
                  if (step_ok) begin
                     pend_valid_in   = 1'b1;
                     pend_in.kind    = nta_pkg::KIND_LOST;
                     pend_in.address = mem_rd_data.address;
                     pend_in.last    = 1'b0;
                  end
               end else begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = wr_ptr_ff[IDX_W-1:0];
                  wr_ptr_in   = wr_ptr_ff + CNT_W'(1);
               end
               if (step_ok) begin
                  idx_in      = idx_next;
                  mem_rd_en   = more;
                  mem_rd_addr = idx_next[IDX_W-1:0];
               end
            end
         end

         ST_FLUSH: begin
            // Send the final word, or an empty one if nothing happened.
            out_valid = 1'b1;
            if (!pend_valid_ff) begin
               out_data.kind    = nta_pkg::KIND_NONE;
               out_data.address = '0;
            end
            out_data.last = 1'b1;
            if (out_ready) begin
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         wr_ptr_ff     <= '0;
         count_ff      <= '0;
         max_age_ff    <= nta_pkg::MAX_AGE_RESET;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         wr_ptr_ff     <= wr_ptr_in;
         count_ff      <= count_in;
         max_age_ff    <= max_age_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      pend_ff <= pend_in;
   end

endmodule

// ===== sv/nta_mem.sv =====
module nta_mem #(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  nta_pkg::entry_type  wr_data,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_addr,
   output nta_pkg::entry_type  rd_data
);

   nta_pkg::entry_type mem [DEPTH];
   nta_pkg::entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/nta_eval.sv =====
module nta_eval (
   input  nta_pkg::entry_type                 entry,
   input  logic [nta_pkg::ADDR_W-1:0]         key_address,
   input  logic [nta_pkg::AGE_W-1:0]          max_age,
   output nta_pkg::eval_type                  result
);

   // Address match for the beacon search, timeout check and age step for the sweep.
   always_comb begin
      result.hit     = (entry.address == key_address);
      result.expired = (entry.age >= max_age);
      result.age_inc = entry.age + nta_pkg::AGE_W'(1);
   end

endmodule

// ===== sv/nta_out.sv =====
module nta_out (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  nta_pkg::rsp_type            in_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [nta_pkg::KIND_W-1:0]  rsp_event_kind,
   output logic [nta_pkg::ADDR_W-1:0]  rsp_event_address,
   output logic                        rsp_last
);

   logic             valid_ff;
   logic             valid_in;
   nta_pkg::rsp_type data_ff;

   // The slot takes a new word when it is empty or being drained this cycle.
   assign in_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_event_kind    = data_ff.kind;
   assign rsp_event_address = data_ff.address;
   assign rsp_last          = data_ff.last;

endmodule

// ===== sv/nta_checker.sv =====
module nta_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [nta_pkg::KIND_W-1:0]  rsp_event_kind,
   input logic [nta_pkg::ADDR_W-1:0]  rsp_event_address,
   input logic                        rsp_last
);

   // A stalled response word holds still.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_kind)
         && $stable(rsp_event_address) && $stable(rsp_last))
      else $error("response word changed while stalled");

   // The block is busy in the cycle after it takes a request.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a request is in work");

   // An empty word is only ever the final word of a request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == nta_pkg::KIND_NONE) |-> rsp_last)
      else $error("empty response word not marked last");

   // Words without a neighbor carry a zero address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_event_kind == nta_pkg::KIND_NONE)
         || (rsp_event_kind == nta_pkg::KIND_FULL)) |-> (rsp_event_address == '0))
      else $error("address set on a word without a neighbor");

endmodule

bind neighbor_table_aging nta_checker u_nta_checker (.*);

// ===== tb/tb_neighbor_table_aging.sv =====
`timescale 1ns / 1ps

module tb_neighbor_table_aging;

   localparam int TABLE_DEPTH = 16;
   localparam int POOL_SIZE   = 24;

   // Mirror of the neighbor table. It predicts the event words of each accepted
   // request and checks the words that leave the block against them in order.
   class neighbor_table_mirror;
      logic [nta_pkg::AGE_W-1:0] max_age;
      nta_pkg::entry_type        rows[TABLE_DEPTH];
      int                        row_count;
      nta_pkg::rsp_type          awaited_events[$];
      int                        mismatches;
      int                        words_checked;
      int                        kind_seen[4];

      function new();
         max_age       = nta_pkg::MAX_AGE_RESET;
         row_count     = 0;
         mismatches    = 0;
         words_checked = 0;
         foreach (rows[i]) rows[i] = '0;
         foreach (kind_seen[k]) kind_seen[k] = 0;
      endfunction

      function nta_pkg::rsp_type make_word(nta_pkg::kind_type kind,
                                           logic [nta_pkg::ADDR_W-1:0] addr);
         nta_pkg::rsp_type w;
         w.kind    = kind;
         w.address = addr;
         w.last    = 1'b0;
         return w;
      endfunction

      // Note an accepted request and queue the event words it must cause.
      function void take_request(logic req_kind, logic [nta_pkg::ADDR_W-1:0] addr);
         nta_pkg::rsp_type words[$];
         nta_pkg::rsp_type closing_word;
         bit               drop[TABLE_DEPTH];
         bit               hit;
         int               w;
         hit = 1'b0;
         if (req_kind == nta_pkg::REQ_BEACON) begin
            // A known address is marked arrived; its age is kept while it is still new.
            for (int i = 0; i < row_count && !hit; i++) begin
               if (rows[i].address == addr) begin
                  hit = 1'b1;
                  rows[i].arrived = 1'b1;
                  if (!rows[i].is_new) rows[i].age = '0;
               end
            end
            if (hit) begin
               words = {words, make_word(nta_pkg::KIND_NONE, '0)};
            end else if (row_count >= TABLE_DEPTH) begin
               words = {words, make_word(nta_pkg::KIND_FULL, '0)};
            end else begin
               rows[row_count].address = addr;
               rows[row_count].age     = '0;
               rows[row_count].is_new  = 1'b1;
               rows[row_count].arrived = 1'b1;
               row_count++;
               words = {words, make_word(nta_pkg::KIND_NONE, '0)};
            end
         end else begin
            // First pass: report new arrivals, age the others and mark the expired ones.
            for (int i = 0; i < row_count; i++) begin
               drop[i] = 1'b0;
               if (rows[i].arrived) begin
                  if (rows[i].is_new) begin
                     words = {words, make_word(nta_pkg::KIND_FOUND, rows[i].address)};
                  end
                  rows[i].is_new  = 1'b0;
                  rows[i].age     = '0;
                  rows[i].arrived = 1'b0;
               end else if (rows[i].is_new) begin
                  rows[i].is_new = 1'b0;
                  rows[i].age    = '0;
               end else if (rows[i].age >= max_age) begin
                  drop[i] = 1'b1;
               end else begin
                  rows[i].age = rows[i].age + 1'b1;
               end
            end
            // Second pass: report lost neighbors and close the gaps they leave.
            w = 0;
            for (int i = 0; i < row_count; i++) begin
               if (drop[i]) begin
                  words = {words, make_word(nta_pkg::KIND_LOST, rows[i].address)};
               end else begin
                  rows[w] = rows[i];
                  w++;
               end
            end
            row_count = w;
            if (words.size() == 0) words = {words, make_word(nta_pkg::KIND_NONE, '0)};
         end
         closing_word      = words.pop_back();
         closing_word.last = 1'b1;
         words             = {words, closing_word};
         awaited_events    = {awaited_events, words};
      endfunction

      // Compare one accepted event word with the oldest prediction.
      function void match_event(logic [nta_pkg::KIND_W-1:0] kind,
                                logic [nta_pkg::ADDR_W-1:0] addr, logic last);
         nta_pkg::rsp_type want;
         if (awaited_events.size() == 0) begin
            $error("unexpected event word: kind %0d address %h last %b", kind, addr, last);
            mismatches++;
            return;
         end
         want = awaited_events.pop_front();
         words_checked++;
         kind_seen[want.kind]++;
         if (want.kind !== kind) begin
            $error("event_kind: expected %0d, actual %0d", want.kind, kind);
            mismatches++;
         end
         if (want.address !== addr) begin
            $error("event_address: expected %h, actual %h", want.address, addr);
            mismatches++;
         end
         if (want.last !== last) begin
            $error("last: expected %b, actual %b", want.last, last);
            mismatches++;
         end
      endfunction
   endclass

   logic                         clock       = 1'b0;
   logic                         reset       = 1'b1;
   logic                         req_valid   = 1'b0;
   logic                         req_type    = nta_pkg::REQ_BEACON;
   logic [nta_pkg::ADDR_W-1:0]   req_address = '0;
   logic                         rsp_ready   = 1'b0;
   logic                         csr_wr_en   = 1'b0;
   logic [nta_pkg::AGE_W-1:0]    csr_wr_data = '0;
   logic                         req_ready;
   logic                         rsp_valid;
   logic [nta_pkg::KIND_W-1:0]   rsp_event_kind;
   logic [nta_pkg::ADDR_W-1:0]   rsp_event_address;
   logic                         rsp_last;

   int                           sender_idle_pct   = 0;
   int                           receiver_idle_pct = 0;
   int                           requests_sent     = 0;
   logic [nta_pkg::ADDR_W-1:0]   address_pool[POOL_SIZE];
   neighbor_table_mirror         mirror;

   neighbor_table_aging #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_address      (req_address),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_event_address(rsp_event_address),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Take event words off the result channel and stall it at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            mirror.match_event(rsp_event_kind, rsp_event_address, rsp_last);
         end
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   function automatic logic [nta_pkg::ADDR_W-1:0] random_address();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[nta_pkg::ADDR_W-1:0];
   endfunction

   // Offer one request word, possibly after an idle gap, and hold it until accepted.
   task automatic send_request(input logic kind, input logic [nta_pkg::ADDR_W-1:0] addr);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_address <= addr;
      do @(posedge clock); while (!req_ready);
      mirror.take_request(kind, addr);
      requests_sent++;
   endtask

   // Stop sending and wait until every predicted word has come out.
   task automatic quiesce();
      req_valid <= 1'b0;
      while (mirror.awaited_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max_age(input logic [nta_pkg::AGE_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mirror.max_age = value;
   endtask

   // One random phase: mostly beacons from a shared pool, so that entries are
   // hit again, mixed with ticks and a few beacons from fresh addresses.
   task automatic run_phase(input int count, input logic [nta_pkg::AGE_W-1:0] age_limit,
                            input int snd_pct, input int rcv_pct);
      int roll;
      quiesce();
      write_max_age(age_limit);
      sender_idle_pct   = snd_pct;
      receiver_idle_pct = rcv_pct;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 5) begin
            address_pool[$urandom_range(POOL_SIZE - 1)] = random_address();
         end
         roll = $urandom_range(99);
         if (roll < 28) begin
            send_request(nta_pkg::REQ_TICK, random_address());
         end else if (roll < 88) begin
            send_request(nta_pkg::REQ_BEACON, address_pool[$urandom_range(POOL_SIZE - 1)]);
         end else begin
            send_request(nta_pkg::REQ_BEACON, random_address());
         end
      end
   endtask

   initial begin
      mirror = new();
      foreach (address_pool[i]) address_pool[i] = random_address();
      address_pool[0]   = '0;
      address_pool[1]   = '1;
      sender_idle_pct   = 12;
      receiver_idle_pct = 71;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty tick, extreme addresses, a repeat beacon on a new
      // entry, filling the table, a dropped beacon, then found, quiet and lost ticks.
      send_request(nta_pkg::REQ_TICK, '1);
      send_request(nta_pkg::REQ_BEACON, '0);
      send_request(nta_pkg::REQ_BEACON, '1);
      send_request(nta_pkg::REQ_BEACON, '0);
      for (int i = 0; i < TABLE_DEPTH - 2; i++) begin
         send_request(nta_pkg::REQ_BEACON, 48'h5 << (3 * i));
      end
      send_request(nta_pkg::REQ_BEACON, 48'h8000_0000_0001);
      send_request(nta_pkg::REQ_TICK, '0);
      send_request(nta_pkg::REQ_TICK, '0);
      send_request(nta_pkg::REQ_BEACON, '1);
      repeat (3) send_request(nta_pkg::REQ_TICK, random_address());

      // Random part across several max_age settings and idle patterns.
      run_phase(29, 8'd1, 12, 71);
      run_phase(29, 8'd0, 12, 71);
      run_phase(29, 8'd255, 71, 12);
      run_phase(29, nta_pkg::AGE_W'($urandom_range(12, 4)), 71, 12);
      run_phase(29, 8'd2, 0, 0);
      run_phase(29, 8'd3, 0, 0);

      quiesce();
      repeat (40) @(posedge clock);
      $display("Sent %0d requests and checked %0d event words", requests_sent,
               mirror.words_checked);
      $display("(%0d found, %0d lost, %0d dropped); max_age ran at 0, 1, 2, 3, 255 %s",
               mirror.kind_seen[nta_pkg::KIND_FOUND], mirror.kind_seen[nta_pkg::KIND_LOST],
               mirror.kind_seen[nta_pkg::KIND_FULL],
               "and one random value, with and without stalls.");
      if (mirror.mismatches == 0) begin
         $display("neighbor_table_aging regression: pass");
      end else begin
         $display("neighbor_table_aging regression: fail");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2_000_000;
      $display("neighbor_table_aging regression: fail");
      $finish;
   end

endmodule
